FILE: hdl/wiper_washer_controller_assert.svh
// Assertion macros for the wiper and washer controller.
`ifndef WIPER_WASHER_CONTROLLER_ASSERT_SVH
`define WIPER_WASHER_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WWC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WWC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WWC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define WWC_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: hdl/wwc_pkg.sv
// Package for the wiper and washer controller: payload types, register indexes, constants.
package wwc_pkg;
  localparam int ADC_BITS_DEF = 10;
  localparam int WASHER_RELEASE_TICKS_DEF = 5;
  localparam int STALL_LIMIT_DEF = 2500;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAUSE_THRESHOLDS = 3'd0,
    REG_PAUSE_TIMES      = 3'd1,
    REG_PRESS_FILTER     = 3'd2,
    REG_RELEASE_FILTER   = 3'd3,
    REG_WASHER_FILTER    = 3'd4,
    REG_PARK_FILTER      = 3'd5,
    REG_AFTER_WASH_PAUSE = 3'd6,
    REG_FRONT_ENABLE     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic       ign_on;
    logic       front_int_switch;
    logic       front_slow_switch;
    logic       front_high_switch;
    logic       front_washer_switch;
    logic       rear_int_switch;
    logic       rear_washer_switch;
    logic       front_park_level;
    logic       rear_park_level;
    logic [9:0] pause_pot_reading;
  } in_beat_t;

  typedef struct packed {
    logic front_slow_drive;
    logic front_high_drive;
    logic rear_drive;
    logic front_stall_fault;
    logic rear_stall_fault;
  } out_beat_t;
endpackage

FILE: hdl/wiper_washer_controller.sv
// Top level of the wiper and washer controller: debounce, mode machines, relay latches.
// One input beat is one tick. It is registered on acceptance and the whole tick update
// (threshold pick, sixteen debounce counters, front and rear mode machines, stall
// counters) runs as shallow logic from that register into the state registers and the
// result register or skid at the next edge, so a beat may be accepted every cycle while
// in_stall is low. The result register is followed by a one-entry skid buffer. in_stall
// rises while the skid holds a beat, or while a beat in the input register is about to
// land on a full result register that the receiver is stalling; with no receiver stall
// it stays low. The user must write configuration through cfg_we/cfg_idx/cfg_data while
// no beat is in flight; the block does not enforce it. Indexes follow the register
// list, the upper bits of cfg_data are dropped as needed. The rear stall check runs on
// the rear park contact. No clearing pass after reset.
module wiper_washer_controller #(
  parameter int ADC_BITS = wwc_pkg::ADC_BITS_DEF,
  parameter int WASHER_RELEASE_TICKS = wwc_pkg::WASHER_RELEASE_TICKS_DEF,
  parameter int STALL_LIMIT = wwc_pkg::STALL_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  wwc_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output wwc_pkg::out_beat_t          out_data,
  input  logic                        cfg_we,
  input  logic [wwc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [wwc_pkg::CFG_DATA_W-1:0] cfg_data
);
`include "wiper_washer_controller_assert.svh"

  localparam logic [7:0] WREL = 8'(WASHER_RELEASE_TICKS);
  localparam logic [11:0] SLIM = 12'(STALL_LIMIT);
  localparam logic [ADC_BITS-1:0] AMASK = '1;

  // debounce counter slots
  localparam int FPY = 0, FPN = 1, RPY = 2, RPN = 3, FWY = 4, FWN = 5, RWY = 6, RWN = 7;
  localparam int FIY = 8, FIN = 9, FSY = 10, FSN = 11, FHY = 12, FHN = 13, RIY = 14, RIN = 15;

  // front flags: int, slow, wash pending, wash held
  localparam int F_INT = 0, F_SLOW = 1, F_WASH = 2, F_WASH2 = 3;
  localparam int R_INT = 0, R_WASH = 1, R_WASH2 = 2;

  // configuration
  logic [5*ADC_BITS-1:0] thr_r;
  logic [59:0] ptimes_r;
  logic [7:0]  press_r, release_r, washf_r, parkf_r;
  logic [15:0] awp_r;
  logic        fen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0; ptimes_r <= '0; press_r <= 8'd5; release_r <= 8'd5;
      washf_r <= 8'd5; parkf_r <= 8'd5; awp_r <= 16'd600; fen_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (wwc_pkg::cfg_reg_t'(cfg_idx))
        wwc_pkg::REG_PAUSE_THRESHOLDS: thr_r <= cfg_data[5*ADC_BITS-1:0];
        wwc_pkg::REG_PAUSE_TIMES:      ptimes_r <= cfg_data[59:0];
        wwc_pkg::REG_PRESS_FILTER:     press_r <= cfg_data[7:0];
        wwc_pkg::REG_RELEASE_FILTER:   release_r <= cfg_data[7:0];
        wwc_pkg::REG_WASHER_FILTER:    washf_r <= cfg_data[7:0];
        wwc_pkg::REG_PARK_FILTER:      parkf_r <= cfg_data[7:0];
        wwc_pkg::REG_AFTER_WASH_PAUSE: awp_r <= cfg_data[15:0];
        wwc_pkg::REG_FRONT_ENABLE:     fen_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake: input register -> compute -> result register + skid
  logic              in_v_r;
  wwc_pkg::in_beat_t in_d_r;
  logic              res_v_r, skid_v_r;
  wwc_pkg::out_beat_t res_d_r, skid_d_r;
  wwc_pkg::out_beat_t res_nxt;

  // hold the input while the skid is full, or while the beat in the input register
  // will land on a full head that is not draining; the skid then takes that beat
  assign in_stall  = skid_v_r || (res_v_r && in_v_r && out_stall);
  assign out_valid = res_v_r;
  assign out_data  = res_d_r;

  logic take_in, res_pop;
  assign take_in = in_valid && !in_stall;
  assign res_pop = res_v_r && !out_stall;

  // state
  logic [7:0]  dbc_r [16];
  logic        fpd_r, fpp_r, fpulse_r, rpark_r, fhigh_r, ignp_r;
  logic [3:0]  fflags_r;
  logic [2:0]  rflags_r;
  logic [15:0] fint_r, fwst_r, rint_r, rwst_r;
  logic [11:0] sc0_r, sc1_r;
  logic        sf0_r, sf1_r;
  logic        dl0_r, dl1_r, dl2_r;

  logic [7:0]  dbc_nxt [16];
  logic        fpd_nxt, fpp_nxt, fpulse_nxt, rpark_nxt, fhigh_nxt, ignp_nxt;
  logic [3:0]  fflags_nxt;
  logic [2:0]  rflags_nxt;
  logic [9:0]  ptsel_nxt;
  logic [15:0] fint_nxt, fwst_nxt, rint_nxt, rwst_nxt;
  logic [11:0] sc0_nxt, sc1_nxt;
  logic        sf0_nxt, sf1_nxt;
  logic        dl0_nxt, dl1_nxt, dl2_nxt;

  // one debounce pair; returns {press, release} edges and updates the pair
  function automatic logic [1:0] deb(input logic lvl, input logic [7:0] onl,
                                     input logic [7:0] offl, inout logic [7:0] on_c,
                                     inout logic [7:0] off_c);
    logic [1:0] e;
    e = 2'b00;
    if (lvl) begin
      off_c = 8'd0;
      if (on_c < onl) on_c = on_c + 8'd1;
      else if (on_c == onl) begin on_c = on_c + 8'd1; e = 2'b10; end
    end else begin
      on_c = 8'd0;
      if (off_c < offl) off_c = off_c + 8'd1;
      else if (off_c == offl) begin off_c = off_c + 8'd1; e = 2'b01; end
    end
    return e;
  endfunction

  always_comb begin
    logic [ADC_BITS-1:0] rd;
    logic [2:0] k;
    logic [1:0] e;
    logic [7:0] c0, c1;
    logic       fp, rp, ign, scan_done;
    logic [15:0] s;
    for (int i = 0; i < 16; i++) dbc_nxt[i] = dbc_r[i];
    fpd_nxt = fpd_r; fpp_nxt = fpp_r; fpulse_nxt = fpulse_r; rpark_nxt = rpark_r;
    fhigh_nxt = fhigh_r; ignp_nxt = ignp_r; fflags_nxt = fflags_r; rflags_nxt = rflags_r;
    fint_nxt = fint_r; fwst_nxt = fwst_r; rint_nxt = rint_r; rwst_nxt = rwst_r;
    sc0_nxt = sc0_r; sc1_nxt = sc1_r; sf0_nxt = sf0_r; sf1_nxt = sf1_r;
    dl0_nxt = dl0_r; dl1_nxt = dl1_r; dl2_nxt = dl2_r;
    ign = in_d_r.ign_on;
    scan_done = 1'b0;

    // pick the pause time: first threshold above the reading
    rd = ADC_BITS'(in_d_r.pause_pot_reading) & AMASK;
    k = 3'd5;
    for (int i = 4; i >= 0; i--)
      if (rd < thr_r[i*ADC_BITS +: ADC_BITS]) k = 3'(i);
    ptsel_nxt = ptimes_r[10*k +: 10];

    // front park contact, with its one-tick parked pulse
    c0 = dbc_nxt[FPY]; c1 = dbc_nxt[FPN];
    e = deb(!in_d_r.front_park_level, parkf_r, press_r, c0, c1);
    dbc_nxt[FPY] = c0; dbc_nxt[FPN] = c1;
    if (e[1]) fpd_nxt = 1'b1;
    if (e[0]) fpd_nxt = 1'b0;
    if (fpp_r != fpd_nxt) begin
      fpp_nxt = fpd_nxt;
      if (fpd_nxt) fpulse_nxt = 1'b1;
    end else fpulse_nxt = 1'b0;

    c0 = dbc_nxt[RPY]; c1 = dbc_nxt[RPN];
    e = deb(!in_d_r.rear_park_level, press_r, press_r, c0, c1);
    dbc_nxt[RPY] = c0; dbc_nxt[RPN] = c1;
    if (e[1]) rpark_nxt = 1'b1;
    if (e[0]) rpark_nxt = 1'b0;

    // washers: held flag while pressed, pending after release
    if (fflags_nxt[F_SLOW] || fhigh_nxt) begin
      fflags_nxt[F_WASH] = 1'b0; fflags_nxt[F_WASH2] = 1'b0;
      dbc_nxt[FWY] = 8'd0; dbc_nxt[FWN] = 8'd0;
    end else if (in_d_r.front_washer_switch) begin
      dbc_nxt[FWN] = 8'd0;
      if (dbc_nxt[FWY] < washf_r) dbc_nxt[FWY] = dbc_nxt[FWY] + 8'd1;
      else if (dbc_nxt[FWY] == washf_r) fflags_nxt[F_WASH2] = 1'b1;
    end else begin
      dbc_nxt[FWY] = 8'd0;
      if (dbc_nxt[FWN] < WREL) dbc_nxt[FWN] = dbc_nxt[FWN] + 8'd1;
      else if (dbc_nxt[FWN] == WREL) begin
        dbc_nxt[FWN] = dbc_nxt[FWN] + 8'd1;
        if (fflags_nxt[F_WASH2]) begin
          fflags_nxt[F_WASH2] = 1'b0; fflags_nxt[F_WASH] = 1'b1;
        end
      end
    end
    if (in_d_r.rear_washer_switch) begin
      dbc_nxt[RWN] = 8'd0;
      if (dbc_nxt[RWY] < washf_r) dbc_nxt[RWY] = dbc_nxt[RWY] + 8'd1;
      else if (dbc_nxt[RWY] == washf_r) rflags_nxt[R_WASH2] = 1'b1;
    end else begin
      dbc_nxt[RWY] = 8'd0;
      if (dbc_nxt[RWN] < WREL) dbc_nxt[RWN] = dbc_nxt[RWN] + 8'd1;
      else if (dbc_nxt[RWN] == WREL) begin
        dbc_nxt[RWN] = dbc_nxt[RWN] + 8'd1;
        if (rflags_nxt[R_WASH2]) begin
          rflags_nxt[R_WASH2] = 1'b0; rflags_nxt[R_WASH] = 1'b1;
        end
      end
    end

    // ignition off: drop modes, high falls back to slow until parked
    if (!ign) begin
      dbc_nxt[FHY] = 8'd0; dbc_nxt[FSY] = 8'd0; dbc_nxt[FIY] = 8'd0; dbc_nxt[RIY] = 8'd0;
      if (fhigh_nxt) begin fhigh_nxt = 1'b0; fflags_nxt = 4'b0010; end
      else fflags_nxt = 4'b0000;
      rflags_nxt = 3'b000;
      scan_done = 1'b1;
    end
    if (!scan_done) begin
      c0 = dbc_nxt[FIY]; c1 = dbc_nxt[FIN];
      e = deb(in_d_r.front_int_switch, press_r, release_r, c0, c1);
      dbc_nxt[FIY] = c0; dbc_nxt[FIN] = c1;
      if (e[1]) fflags_nxt[F_INT] = 1'b1;
      if (e[0]) fflags_nxt[F_INT] = 1'b0;
      c0 = dbc_nxt[FSY]; c1 = dbc_nxt[FSN];
      e = deb(in_d_r.front_slow_switch, press_r, release_r, c0, c1);
      dbc_nxt[FSY] = c0; dbc_nxt[FSN] = c1;
      if (e[1]) fflags_nxt[F_SLOW] = 1'b1;
      if (e[0]) fflags_nxt[F_SLOW] = 1'b0;
      c0 = dbc_nxt[FHY]; c1 = dbc_nxt[FHN];
      e = deb(in_d_r.front_high_switch, press_r, press_r, c0, c1);
      dbc_nxt[FHY] = c0; dbc_nxt[FHN] = c1;
      if (e[1]) fhigh_nxt = 1'b1;
      if (e[0]) begin
        dbc_nxt[FSN] = 8'd0;
        if (fhigh_nxt) fflags_nxt[F_SLOW] = 1'b1;
        fhigh_nxt = 1'b0;
      end
      c0 = dbc_nxt[RIY]; c1 = dbc_nxt[RIN];
      e = deb(in_d_r.rear_int_switch, press_r, release_r, c0, c1);
      dbc_nxt[RIY] = c0; dbc_nxt[RIN] = c1;
      if (e[1]) rflags_nxt[R_INT] = 1'b1;
      if (e[0]) rflags_nxt[R_INT] = 1'b0;
    end

    // front mode machine
    fp = fpulse_nxt;
    if (fen_r) begin
      if (sf0_nxt && (!fhigh_nxt || fflags_nxt == 4'b0000)) begin
        dl0_nxt = 1'b0; dl1_nxt = 1'b0; sf0_nxt = 1'b0;
      end
      if (fhigh_nxt) begin
        fwst_nxt = '0; fint_nxt = '0; dl0_nxt = 1'b1; dl1_nxt = 1'b1;
      end else if (fflags_nxt[F_SLOW] || fflags_nxt[F_WASH2]) begin
        fwst_nxt = '0; fint_nxt = '0; dl1_nxt = 1'b0; dl0_nxt = 1'b1;
      end else if (fflags_nxt[F_WASH]) begin
        fint_nxt = '0;
        if (fwst_nxt == 16'd0) begin
          dl0_nxt = 1'b1;
          if (fp) fwst_nxt = fwst_nxt + 16'd1;
        end else if (fwst_nxt == 16'd1 || fwst_nxt == 16'd2) begin
          dl0_nxt = 1'b1;
          if (fp) begin dl0_nxt = 1'b0; fwst_nxt = fwst_nxt + 16'd1; end
        end else if (fwst_nxt < awp_r) begin
          dl0_nxt = 1'b0; fwst_nxt = fwst_nxt + 16'd1;
        end else if (fwst_nxt == awp_r) begin
          dl0_nxt = 1'b1;
          if (!fp) begin fwst_nxt = '0; fflags_nxt[F_WASH] = 1'b0; end
        end else fwst_nxt = '0;
      end else if (fflags_nxt[F_INT]) begin
        fwst_nxt = '0;
        if (fint_nxt == 16'd0) begin
          dl0_nxt = 1'b1;
          if (!fp) fint_nxt = 16'd1;
        end else if (fint_nxt < {6'd0, ptsel_nxt}) begin
          fint_nxt = fint_nxt + 16'd1;
          if (fp) dl0_nxt = 1'b0;
        end else fint_nxt = '0;
      end else begin
        fint_nxt = '0; fwst_nxt = '0; fflags_nxt = 4'b0000;
        if (fp) dl0_nxt = 1'b0;
      end
      // stall watch on the front park pulse
      if (!dl0_nxt) sc0_nxt = '0;
      else if (fp) begin sc0_nxt = '0; sf0_nxt = 1'b0; end
      else if (sc0_nxt >= SLIM) begin sc0_nxt = '0; sf0_nxt = 1'b1; end
      else sc0_nxt = sc0_nxt + 12'd1;
    end

    // rear mode machine, judged on the rear park contact
    rp = rpark_nxt;
    s = rwst_nxt;
    if (sf1_nxt && rflags_nxt == 3'b000) begin dl2_nxt = 1'b0; sf1_nxt = 1'b0; end
    if (ignp_nxt != ign) begin
      ignp_nxt = ign;
      if (ign && !rp) dl2_nxt = 1'b1;
    end
    if (rflags_nxt[R_WASH2]) begin
      dl2_nxt = 1'b1; rwst_nxt = '0; rint_nxt = '0;
    end else if (rflags_nxt[R_WASH]) begin
      rint_nxt = '0;
      if (s <= 16'd4) begin
        dl2_nxt = 1'b1;
        if ((s[0] == 1'b0) == rp) rwst_nxt = rwst_nxt + 16'd1;
      end else if (s < awp_r) begin
        dl2_nxt = 1'b0; rwst_nxt = rwst_nxt + 16'd1;
      end else if (s == awp_r) begin
        dl2_nxt = 1'b1;
        if (!rp) begin rwst_nxt = '0; rflags_nxt[R_WASH] = 1'b0; end
      end
    end else if (rflags_nxt[R_INT]) begin
      rwst_nxt = '0;
      if (rint_nxt == 16'd0) begin
        dl2_nxt = 1'b1;
        if (!rp) rint_nxt = 16'd1;
      end else if (rint_nxt < awp_r) begin
        rint_nxt = rint_nxt + 16'd1;
        if (rp) dl2_nxt = 1'b0;
      end else rint_nxt = '0;
    end else begin
      rwst_nxt = '0; rint_nxt = '0; rflags_nxt = 3'b000;
      if (rp) dl2_nxt = 1'b0;
    end
    if (!dl2_nxt) sc1_nxt = '0;
    else if (rp) begin sc1_nxt = '0; sf1_nxt = 1'b0; end
    else if (sc1_nxt >= SLIM) begin sc1_nxt = '0; sf1_nxt = 1'b1; end
    else sc1_nxt = sc1_nxt + 12'd1;

    res_nxt.front_slow_drive  = dl0_nxt;
    res_nxt.front_high_drive  = dl1_nxt;
    res_nxt.rear_drive        = dl2_nxt;
    res_nxt.front_stall_fault = sf0_nxt;
    res_nxt.rear_stall_fault  = sf1_nxt;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) in_v_r <= 1'b0;
    else in_v_r <= take_in;
    if (take_in) in_d_r <= in_data;
  end

  // tick state advances once per registered beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) dbc_r[i] <= 8'd0;
      fpd_r <= 1'b0; fpp_r <= 1'b0; fpulse_r <= 1'b0; rpark_r <= 1'b0;
      fhigh_r <= 1'b0; ignp_r <= 1'b0; fflags_r <= '0; rflags_r <= '0;
      fint_r <= '0; fwst_r <= '0; rint_r <= '0; rwst_r <= '0;
      sc0_r <= '0; sc1_r <= '0; sf0_r <= 1'b0; sf1_r <= 1'b0;
      dl0_r <= 1'b0; dl1_r <= 1'b0; dl2_r <= 1'b0;
    end else if (in_v_r) begin
      for (int i = 0; i < 16; i++) dbc_r[i] <= dbc_nxt[i];
      fpd_r <= fpd_nxt; fpp_r <= fpp_nxt; fpulse_r <= fpulse_nxt; rpark_r <= rpark_nxt;
      fhigh_r <= fhigh_nxt; ignp_r <= ignp_nxt; fflags_r <= fflags_nxt;
      rflags_r <= rflags_nxt;
      fint_r <= fint_nxt; fwst_r <= fwst_nxt; rint_r <= rint_nxt; rwst_r <= rwst_nxt;
      sc0_r <= sc0_nxt; sc1_r <= sc1_nxt; sf0_r <= sf0_nxt; sf1_r <= sf1_nxt;
      dl0_r <= dl0_nxt; dl1_r <= dl1_nxt; dl2_r <= dl2_nxt;
    end
  end

  // result register with a one-beat skid; hold the skid until the head drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0; skid_v_r <= 1'b0;
    end else begin
      priority if (res_pop) begin
        if (skid_v_r) begin
          res_v_r <= 1'b1; res_d_r <= skid_d_r;
          skid_v_r <= in_v_r;
          if (in_v_r) skid_d_r <= res_nxt;
        end else begin
          res_v_r <= in_v_r;
          if (in_v_r) res_d_r <= res_nxt;
        end
      end else if (in_v_r) begin
        if (!res_v_r) begin
          res_v_r <= 1'b1; res_d_r <= res_nxt;
        end else begin
          skid_v_r <= 1'b1; skid_d_r <= res_nxt;
        end
      end else begin
        res_v_r <= res_v_r;
      end
    end
  end

  `WWC_ASSERT_IMPL(a_skid_needs_head, clk, rst_n, skid_v_r |-> res_v_r, "skid full with empty head")
  `WWC_ASSERT_IMPL(a_no_overflow, clk, rst_n, (in_v_r && res_v_r && skid_v_r) |-> res_pop, "result beat dropped")
  `WWC_ASSERT_IMPL(a_beat_lands, clk, rst_n, take_in |=> in_v_r, "accepted beat lost")
  `WWC_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")
endmodule

FILE: tb/sv/wwc_scoreboard.sv
// Scoreboard for the wiper and washer controller: tick predictor and result check.
`timescale 1ns / 1ps
class wwc_scoreboard;
  localparam int FPARK_Y = 0, FPARK_N = 1, RPARK_Y = 2, RPARK_N = 3;
  localparam int FWASH_ON = 4, FWASH_OFF = 5, RWASH_ON = 6, RWASH_OFF = 7;
  localparam int FINT_ON = 8, FINT_OFF = 9, FSLOW_ON = 10, FSLOW_OFF = 11;
  localparam int FHIGH_ON = 12, FHIGH_OFF = 13, RINT_ON = 14, RINT_OFF = 15;
  localparam logic [3:0] F_INT = 4'd1, F_SLOW = 4'd2, F_WASH = 4'd4, F_WASH2 = 4'd8;
  localparam logic [2:0] R_INT = 3'd1, R_WASH = 3'd2, R_WASH2 = 3'd4;
  localparam int STALL_LIMIT = wwc_pkg::STALL_LIMIT_DEF;
  localparam int WASH_REL = wwc_pkg::WASHER_RELEASE_TICKS_DEF;

  logic [49:0] thr;
  logic [59:0] ptimes;
  logic [7:0] press_f, release_f, washer_f, park_f;
  logic [15:0] aw_pause;
  bit f_en;

  logic [7:0] cnt[16];
  bit fpark_db, fpark_prev, fpark_pulse, rparked, fhigh_req, ign_prev;
  logic [3:0] fmode;
  logic [2:0] rmode;
  logic [9:0] psel;
  logic [15:0] fint_cnt, fwash_step, rint_cnt, rwash_step;
  logic [11:0] stall_cnt[2];
  bit stall_flt[2];
  bit drv[3];

  wwc_pkg::out_beat_t pending_beats[$];
  int errors;

  function new();
    thr = '0; ptimes = '0;
    press_f = 5; release_f = 5; washer_f = 5; park_f = 5;
    aw_pause = 600; f_en = 1;
    foreach (cnt[i]) cnt[i] = 0;
    fpark_db = 0; fpark_prev = 0; fpark_pulse = 0; rparked = 0;
    fhigh_req = 0; ign_prev = 0; fmode = 0; rmode = 0; psel = 0;
    fint_cnt = 0; fwash_step = 0; rint_cnt = 0; rwash_step = 0;
    stall_cnt[0] = 0; stall_cnt[1] = 0; stall_flt[0] = 0; stall_flt[1] = 0;
    drv[0] = 0; drv[1] = 0; drv[2] = 0;
    errors = 0;
  endfunction

  function void write_reg(wwc_pkg::cfg_reg_t idx, logic [59:0] v);
    case (idx)
      wwc_pkg::REG_PAUSE_THRESHOLDS: thr = v[49:0];
      wwc_pkg::REG_PAUSE_TIMES:      ptimes = v;
      wwc_pkg::REG_PRESS_FILTER:     press_f = v[7:0];
      wwc_pkg::REG_RELEASE_FILTER:   release_f = v[7:0];
      wwc_pkg::REG_WASHER_FILTER:    washer_f = v[7:0];
      wwc_pkg::REG_PARK_FILTER:      park_f = v[7:0];
      wwc_pkg::REG_AFTER_WASH_PAUSE: aw_pause = v[15:0];
      wwc_pkg::REG_FRONT_ENABLE:     f_en = v[0];
      default: ;
    endcase
  endfunction

  // +1 on press edge, -1 on release edge
  function int filter(int on_i, int off_i, bit lvl, logic [7:0] on_lim, logic [7:0] off_lim);
    if (lvl) begin
      cnt[off_i] = 0;
      if (cnt[on_i] < on_lim) cnt[on_i]++;
      else if (cnt[on_i] == on_lim) begin cnt[on_i]++; return 1; end
    end else begin
      cnt[on_i] = 0;
      if (cnt[off_i] < off_lim) cnt[off_i]++;
      else if (cnt[off_i] == off_lim) begin cnt[off_i]++; return -1; end
    end
    return 0;
  endfunction

  function void washer_front(bit lvl);
    if (lvl) begin
      cnt[FWASH_OFF] = 0;
      if (cnt[FWASH_ON] < washer_f) cnt[FWASH_ON]++;
      else if (cnt[FWASH_ON] == washer_f) fmode |= F_WASH2;
    end else begin
      cnt[FWASH_ON] = 0;
      if (cnt[FWASH_OFF] < WASH_REL) cnt[FWASH_OFF]++;
      else if (cnt[FWASH_OFF] == WASH_REL) begin
        cnt[FWASH_OFF]++;
        if (fmode & F_WASH2) begin fmode &= ~F_WASH2; fmode |= F_WASH; end
      end
    end
  endfunction

  function void washer_rear(bit lvl);
    if (lvl) begin
      cnt[RWASH_OFF] = 0;
      if (cnt[RWASH_ON] < washer_f) cnt[RWASH_ON]++;
      else if (cnt[RWASH_ON] == washer_f) rmode |= R_WASH2;
    end else begin
      cnt[RWASH_ON] = 0;
      if (cnt[RWASH_OFF] < WASH_REL) cnt[RWASH_OFF]++;
      else if (cnt[RWASH_OFF] == WASH_REL) begin
        cnt[RWASH_OFF]++;
        if (rmode & R_WASH2) begin rmode &= ~R_WASH2; rmode |= R_WASH; end
      end
    end
  endfunction

  function void stall_step(int i, bit driving, bit parked);
    if (!driving) begin stall_cnt[i] = 0; return; end
    if (parked) begin stall_cnt[i] = 0; stall_flt[i] = 0; end
    else if (stall_cnt[i] >= STALL_LIMIT) begin stall_cnt[i] = 0; stall_flt[i] = 1; end
    else stall_cnt[i]++;
  endfunction

  function void scan(wwc_pkg::in_beat_t b);
    int k, e;
    for (k = 0; k < 5; k++)
      if (b.pause_pot_reading < thr[k*10 +: 10]) break;
    psel = ptimes[k*10 +: 10];
    e = filter(FPARK_Y, FPARK_N, !b.front_park_level, park_f, press_f);
    if (e > 0) fpark_db = 1;
    if (e < 0) fpark_db = 0;
    if (fpark_prev != fpark_db) begin
      fpark_prev = fpark_db;
      if (fpark_db) fpark_pulse = 1;
    end else fpark_pulse = 0;
    e = filter(RPARK_Y, RPARK_N, !b.rear_park_level, press_f, press_f);
    if (e > 0) rparked = 1;
    if (e < 0) rparked = 0;
    if ((fmode & F_SLOW) || fhigh_req) begin
      fmode &= ~(F_WASH | F_WASH2);
      cnt[FWASH_ON] = 0; cnt[FWASH_OFF] = 0;
    end else washer_front(b.front_washer_switch);
    washer_rear(b.rear_washer_switch);
    if (!b.ign_on) begin
      cnt[FHIGH_ON] = 0; cnt[FSLOW_ON] = 0; cnt[FINT_ON] = 0; cnt[RINT_ON] = 0;
      if (fhigh_req) begin fhigh_req = 0; fmode = F_SLOW; end
      else fmode = 0;
      rmode = 0;
      return;
    end
    e = filter(FINT_ON, FINT_OFF, b.front_int_switch, press_f, release_f);
    if (e > 0) fmode |= F_INT;
    if (e < 0) fmode &= ~F_INT;
    e = filter(FSLOW_ON, FSLOW_OFF, b.front_slow_switch, press_f, release_f);
    if (e > 0) fmode |= F_SLOW;
    if (e < 0) fmode &= ~F_SLOW;
    e = filter(FHIGH_ON, FHIGH_OFF, b.front_high_switch, press_f, press_f);
    if (e > 0) fhigh_req = 1;
    if (e < 0) begin
      cnt[FSLOW_OFF] = 0;
      if (fhigh_req) fmode |= F_SLOW;
      fhigh_req = 0;
    end
    e = filter(RINT_ON, RINT_OFF, b.rear_int_switch, press_f, release_f);
    if (e > 0) rmode |= R_INT;
    if (e < 0) rmode &= ~R_INT;
  endfunction

  function void front_step();
    bit p;
    p = fpark_pulse;
    if (!f_en) return;
    if (stall_flt[0] && (!fhigh_req || fmode == 0)) begin
      drv[0] = 0; drv[1] = 0; stall_flt[0] = 0;
    end
    if (fhigh_req) begin
      fwash_step = 0; fint_cnt = 0; drv[0] = 1; drv[1] = 1;
    end else if (fmode & (F_SLOW | F_WASH2)) begin
      fwash_step = 0; fint_cnt = 0; drv[1] = 0; drv[0] = 1;
    end else if (fmode & F_WASH) begin
      fint_cnt = 0;
      if (fwash_step == 0) begin
        drv[0] = 1;
        if (p) fwash_step++;
      end else if (fwash_step == 1 || fwash_step == 2) begin
        drv[0] = 1;
        if (p) begin drv[0] = 0; fwash_step++; end
      end else if (fwash_step < aw_pause) begin
        drv[0] = 0; fwash_step++;
      end else if (fwash_step == aw_pause) begin
        drv[0] = 1;
        if (!p) begin fwash_step = 0; fmode &= ~F_WASH; end
      end else fwash_step = 0;
    end else if (fmode & F_INT) begin
      fwash_step = 0;
      if (fint_cnt == 0) begin
        drv[0] = 1;
        if (!p) fint_cnt++;
      end else if (fint_cnt < psel) begin
        fint_cnt++;
        if (p) drv[0] = 0;
      end else fint_cnt = 0;
    end else begin
      fint_cnt = 0; fwash_step = 0; fmode = 0;
      if (p) drv[0] = 0;
    end
    stall_step(0, drv[0], p);
  endfunction

  function void rear_step(bit ign);
    bit p;
    logic [15:0] s;
    p = rparked;
    s = rwash_step;
    if (stall_flt[1] && rmode == 0) begin drv[2] = 0; stall_flt[1] = 0; end
    if (ign_prev != ign) begin
      ign_prev = ign;
      if (ign && !p) drv[2] = 1;
    end
    if (rmode & R_WASH2) begin
      drv[2] = 1; rwash_step = 0; rint_cnt = 0;
    end else if (rmode & R_WASH) begin
      rint_cnt = 0;
      if (s <= 4) begin
        drv[2] = 1;
        // even steps wait for park, odd steps for leaving it
        if ((s[0] == 1'b0) == p) rwash_step++;
      end else if (s < aw_pause) begin
        drv[2] = 0; rwash_step++;
      end else if (s == aw_pause) begin
        drv[2] = 1;
        if (!p) begin rwash_step = 0; rmode &= ~R_WASH; end
      end
    end else if (rmode & R_INT) begin
      rwash_step = 0;
      if (rint_cnt == 0) begin
        drv[2] = 1;
        if (!p) rint_cnt++;
      end else if (rint_cnt < aw_pause) begin
        rint_cnt++;
        if (p) drv[2] = 0;
      end else rint_cnt = 0;
    end else begin
      rwash_step = 0; rint_cnt = 0; rmode = 0;
      if (p) drv[2] = 0;
    end
    stall_step(1, drv[2], p);
  endfunction

  function void note_tick(wwc_pkg::in_beat_t b);
    wwc_pkg::out_beat_t r;
    scan(b);
    front_step();
    rear_step(b.ign_on);
    r.front_slow_drive = drv[0];
    r.front_high_drive = drv[1];
    r.rear_drive = drv[2];
    r.front_stall_fault = stall_flt[0];
    r.rear_stall_fault = stall_flt[1];
    pending_beats.push_back(r);
  endfunction

  function void check_drive(wwc_pkg::out_beat_t got);
    wwc_pkg::out_beat_t want;
    if (pending_beats.size() == 0) begin
      $display("%0t: unexpected result beat %b", $time, got);
      errors++;
      return;
    end
    want = pending_beats.pop_front();
    if (got !== want) begin
      $display("%0t: result mismatch expected slow=%b high=%b rear=%b ff=%b rf=%b",
               $time, want.front_slow_drive, want.front_high_drive, want.rear_drive,
               want.front_stall_fault, want.rear_stall_fault);
      $display("%0t:                 actual   slow=%b high=%b rear=%b ff=%b rf=%b",
               $time, got.front_slow_drive, got.front_high_drive, got.rear_drive,
               got.front_stall_fault, got.rear_stall_fault);
      errors++;
    end
  endfunction
endclass

FILE: tb/sv/testbench.sv
// Top-level testbench of the wiper and washer controller: stimulus, idling, end of run.
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wwc_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wwc_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [wwc_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [wwc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  wwc_scoreboard sb = new();

  // Idling odds in percent, set per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Long hold-off of the receiver, counted down in its own process
  int hold_off_cycles = 0;
  longint cycles = 0;

  wiper_washer_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** wiper_washer_controller: FAILED **");
      $finish;
    end
  end

  // Receiver: pick the stall for the next cycle, check accepted beats.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_drive(out_data);
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Write one register while nothing is in flight.
  task automatic write_cfg(wwc_pkg::cfg_reg_t idx, logic [wwc_pkg::CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Offer one beat, with random gaps first; hold it until accepted.
  task automatic send_tick(wwc_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.note_tick(b);
  endtask

  // Drain: drop valid, wait for every result, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Switches held for runs so debounce filters see stable levels;
  // park contacts toggle like a turning motor.
  wwc_pkg::in_beat_t cur;
  task automatic random_ticks(int n);
    int run;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 6) begin
        cur[18:10] = 9'($urandom());
        cur.ign_on = ($urandom_range(9) != 0);
      end
      if ($urandom_range(99) < 15) cur.front_park_level = ~cur.front_park_level;
      if ($urandom_range(99) < 15) cur.rear_park_level = ~cur.rear_park_level;
      if ($urandom_range(99) < 3) cur.pause_pot_reading = 10'($urandom());
      // Occasional single-tick glitch on a switch, the ignition or a park contact
      run = $urandom_range(99);
      if (run < 4) begin
        wwc_pkg::in_beat_t g;
        g = cur;
        g[18:10] = g[18:10] ^ (9'd1 << $urandom_range(8));
        send_tick(g);
      end else send_tick(cur);
    end
  endtask

  task automatic set_config(int lvl);
    logic [59:0] v;
    case (lvl)
      0: begin
        write_cfg(wwc_pkg::REG_PAUSE_THRESHOLDS,
                  60'({10'd900, 10'd700, 10'd500, 10'd300, 10'd100}));
        write_cfg(wwc_pkg::REG_PAUSE_TIMES, {10'd60, 10'd40, 10'd25, 10'd15, 10'd8, 10'd3});
        write_cfg(wwc_pkg::REG_PRESS_FILTER, 60'd2);
        write_cfg(wwc_pkg::REG_RELEASE_FILTER, 60'd3);
        write_cfg(wwc_pkg::REG_WASHER_FILTER, 60'd2);
        write_cfg(wwc_pkg::REG_PARK_FILTER, 60'd1);
        write_cfg(wwc_pkg::REG_AFTER_WASH_PAUSE, 60'd20);
        write_cfg(wwc_pkg::REG_FRONT_ENABLE, 60'd1);
      end
      1: begin
        // Low extremes: zero filters, pause below five
        write_cfg(wwc_pkg::REG_PAUSE_THRESHOLDS, '1);
        write_cfg(wwc_pkg::REG_PAUSE_TIMES, '0);
        write_cfg(wwc_pkg::REG_PRESS_FILTER, 60'd0);
        write_cfg(wwc_pkg::REG_RELEASE_FILTER, 60'd0);
        write_cfg(wwc_pkg::REG_WASHER_FILTER, 60'd0);
        write_cfg(wwc_pkg::REG_PARK_FILTER, 60'd0);
        write_cfg(wwc_pkg::REG_AFTER_WASH_PAUSE, 60'd3);
        write_cfg(wwc_pkg::REG_FRONT_ENABLE, 60'd0);
      end
      2: begin
        // High extremes: filters at 254, long pause
        write_cfg(wwc_pkg::REG_PAUSE_THRESHOLDS, '0);
        write_cfg(wwc_pkg::REG_PAUSE_TIMES, '1);
        write_cfg(wwc_pkg::REG_PRESS_FILTER, 60'd254);
        write_cfg(wwc_pkg::REG_RELEASE_FILTER, 60'd254);
        write_cfg(wwc_pkg::REG_WASHER_FILTER, 60'd254);
        write_cfg(wwc_pkg::REG_PARK_FILTER, 60'd254);
        write_cfg(wwc_pkg::REG_AFTER_WASH_PAUSE, 60'd65535);
        write_cfg(wwc_pkg::REG_FRONT_ENABLE, 60'd1);
      end
      default: begin
        v = 60'({$urandom(), $urandom()});
        write_cfg(wwc_pkg::REG_PAUSE_THRESHOLDS, v);
        v = 60'({$urandom(), $urandom()});
        write_cfg(wwc_pkg::REG_PAUSE_TIMES, v);
        write_cfg(wwc_pkg::REG_PRESS_FILTER, 60'($urandom_range(4)));
        write_cfg(wwc_pkg::REG_RELEASE_FILTER, 60'($urandom_range(4)));
        write_cfg(wwc_pkg::REG_WASHER_FILTER, 60'($urandom_range(4)));
        write_cfg(wwc_pkg::REG_PARK_FILTER, 60'($urandom_range(4)));
        write_cfg(wwc_pkg::REG_AFTER_WASH_PAUSE, 60'($urandom_range(3, 30)));
        write_cfg(wwc_pkg::REG_FRONT_ENABLE, 60'($urandom_range(1)));
      end
    endcase
  endtask

  initial begin
    wwc_pkg::in_beat_t d;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: default filters, field extremes, ignition off with high held.
    d = '0;
    send_tick(d);
    d = '1;
    repeat (8) send_tick(d);
    d = '0;
    d.ign_on = 1'b1;
    d.front_high_switch = 1'b1;
    repeat (7) send_tick(d);
    d.ign_on = 1'b0;
    repeat (3) send_tick(d);
    d = '0;
    d.pause_pot_reading = 10'h3ff;
    d.front_park_level = 1'b1;
    d.rear_park_level = 1'b1;
    repeat (5) send_tick(d);
    drain();

    // Phases: each setting runs under a different idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      set_config(ph < 3 ? ph : 3);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      cur = '0;
      cur.ign_on = 1'b1;
      // Long hold-off so the block fills and stalls its input
      if (ph == 0) hold_off_cycles = 40;
      random_ticks(150);
      drain();
    end

    drain();
    if (sb.errors == 0) begin
      $display("** wiper_washer_controller: PASSED **");
    end else begin
      $display("** wiper_washer_controller: FAILED **");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/wwc_pkg.sv
hdl/wiper_washer_controller.sv
tb/sv/wwc_scoreboard.sv
tb/sv/testbench.sv
